/* rtl/core/ate_pkg.sv */
// ate_pkg: shared types and constants for the array table engine
// item structs, operation and status codes, capacity defaults
// no dependencies
package ate_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned MAX_RESULTS  = 64;

	// operation codes
	localparam logic [2:0] OP_FRONT  = 3'd0;
	localparam logic [2:0] OP_APPEND = 3'd1;
	localparam logic [2:0] OP_INS_AT = 3'd2;
	localparam logic [2:0] OP_DEL_AT = 3'd3;
	localparam logic [2:0] OP_SORT   = 3'd4;
	localparam logic [2:0] OP_LFIND  = 3'd5;
	localparam logic [2:0] OP_BFIND  = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_BAD_POS = 2'd2;
	localparam logic [1:0] ST_MISS    = 2'd3;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] value;
		logic [6:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] found_index;
		logic [6:0] count;
		logic       last;
	} rsp_t;

	// flags from the shared comparator
	typedef struct packed {
		logic eq;
		logic gt;
		logic lt;
	} cmp_t;

endpackage

/* rtl/core/array_table_engine_unit.sv */
// array_table_engine_unit: top level, sequencer around one entry ram and one comparator
// depends on ate_pkg, ate_ram, ate_cmp
//
// channel | direction | handshake         | payload
// req     | in        | req_valid/req_stall | req_t: mode, value, position
// rsp     | out       | rsp_valid/rsp_stall | rsp_t: status, found_index, count, last
//
// one item at a time; req_stall is high from acceptance until its last result is taken
// the single ram read port sets the pace: each entry moved or scanned, each insertion sort
// shift step and each binary search probe takes a read state and then a compare or write state
// each result sits in the output register, held while rsp_stall
// reset clears the fill count and sequencer state only; entries are unknown until written
module array_table_engine_unit
	import ate_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW  = $clog2(CAPACITY + 1);
	localparam int unsigned PW  = (CW > 7) ? CW : 7;
	localparam int unsigned SW  = CW + 2;
	localparam int unsigned MW  = $clog2(MAX_RESULTS + 1);

	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_MV_RD   = 14'b00000000000010,
		S_MV_WR   = 14'b00000000000100,
		S_INS_PUT = 14'b00000000001000,
		S_SRT_LD  = 14'b00000000010000,
		S_SRT_KEY = 14'b00000000100000,
		S_SRT_RD  = 14'b00000001000000,
		S_SRT_CMP = 14'b00000010000000,
		S_SRT_PUT = 14'b00000100000000,
		S_LIN_RD  = 14'b00001000000000,
		S_LIN_CMP = 14'b00010000000000,
		S_BIN_RD  = 14'b00100000000000,
		S_BIN_CMP = 14'b01000000000000,
		S_EMIT    = 14'b10000000000000
	} state_t;

	state_t             state_q, ret_q;
	logic [CW-1:0]      fill_q, i_q, j_q, pos_q, pend_idx_q;
	logic               up_q, pend_q;
	logic [MW-1:0]      n_q;
	logic [2:0]         mode_q;
	logic signed [31:0] key_q, find_q;
	logic signed [SW-1:0] lo_q, hi_q, mid_q;
	rsp_t               rsp_q;

	logic               we;
	logic [AW-1:0]      waddr, raddr;
	logic signed [31:0] wdata, rdata;
	cmp_t               cmp;
	logic signed [SW:0] mid_sum;
	logic signed [SW-1:0] mid;
	logic [PW-1:0]      pos_ext, fill_ext;
	logic               full;

	ate_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	ate_cmp u_cmp (
		.a   (rdata),
		.b   (key_q),
		.res (cmp)
	);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_EMIT);
	assign rsp       = rsp_q;

	assign pos_ext  = PW'(req.position);
	assign fill_ext = PW'(fill_q);
	assign full     = (fill_q == CW'(CAPACITY));
	assign mid_sum  = (SW+1)'(lo_q) + (SW+1)'(hi_q);
	assign mid      = SW'(mid_sum >>> 1);

	// ram port control per state
	always_comb begin
		we    = 1'b0;
		waddr = AW'(i_q);
		wdata = rdata;
		raddr = AW'(i_q);
		case (state_q)
			S_MV_RD:   raddr = up_q ? AW'(i_q - 1'b1) : AW'(i_q + 1'b1);
			S_MV_WR:   we = 1'b1;
			S_INS_PUT: begin
				we    = 1'b1;
				waddr = AW'(pos_q);
				wdata = key_q;
			end
			S_SRT_RD:  raddr = AW'(j_q - 1'b1);
			S_SRT_CMP: begin
				we    = cmp.gt;
				waddr = AW'(j_q);
			end
			S_SRT_PUT: begin
				we    = 1'b1;
				waddr = AW'(j_q);
				wdata = key_q;
			end
			S_BIN_RD:  raddr = AW'(mid);
			default:   ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			fill_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mode_q <= req.mode;
						key_q  <= req.value;
						find_q <= req.value;
						ret_q  <= S_IDLE;
						rsp_q  <= '{status: ST_OK, found_index: '0, count: 7'(fill_q), last: 1'b1};
						state_q <= S_EMIT;
						case (req.mode)
							OP_FRONT, OP_APPEND: begin
								if (full) begin
									rsp_q.status <= ST_FULL;
								end else begin
									up_q    <= 1'b1;
									i_q     <= fill_q;
									pos_q   <= (req.mode == OP_FRONT) ? '0 : fill_q;
									state_q <= S_MV_RD;
								end
							end
							OP_INS_AT: begin
								if (pos_ext > fill_ext) begin
									rsp_q.status <= ST_BAD_POS;
								end else if (full) begin
									rsp_q.status <= ST_FULL;
								end else begin
									up_q    <= 1'b1;
									i_q     <= fill_q;
									pos_q   <= CW'(pos_ext);
									state_q <= S_MV_RD;
								end
							end
							OP_DEL_AT: begin
								if (pos_ext >= fill_ext) begin
									rsp_q.status <= ST_BAD_POS;
								end else begin
									up_q    <= 1'b0;
									i_q     <= CW'(pos_ext);
									state_q <= S_MV_RD;
								end
							end
							OP_SORT, OP_BFIND: begin
								i_q     <= CW'(1);
								state_q <= S_SRT_LD;
							end
							OP_LFIND: begin
								i_q     <= '0;
								n_q     <= '0;
								pend_q  <= 1'b0;
								state_q <= S_LIN_RD;
							end
							default: ;
						endcase
					end
				end
				// shift entries up for insert or down for delete
				S_MV_RD: begin
					if (up_q && i_q == pos_q) begin
						state_q <= S_INS_PUT;
					end else if (!up_q && (i_q + 1'b1) >= fill_q) begin
						fill_q  <= fill_q - 1'b1;
						rsp_q.count <= 7'(fill_q - 1'b1);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_MV_WR;
					end
				end
				S_MV_WR: begin
					i_q     <= up_q ? i_q - 1'b1 : i_q + 1'b1;
					state_q <= S_MV_RD;
				end
				S_INS_PUT: begin
					fill_q  <= fill_q + 1'b1;
					rsp_q.count <= 7'(fill_q + 1'b1);
					state_q <= S_EMIT;
				end
				// insertion sort
				S_SRT_LD: begin
					if (i_q >= fill_q) begin
						if (mode_q == OP_BFIND) begin
							// sort used key_q for its own keys, bring back the search key
							key_q   <= find_q;
							lo_q    <= '0;
							hi_q    <= SW'(fill_q) - 1'b1;
							state_q <= S_BIN_RD;
						end else begin
							state_q <= S_EMIT;
						end
					end else begin
						state_q <= S_SRT_KEY;
					end
				end
				S_SRT_KEY: begin
					key_q   <= rdata;
					j_q     <= i_q;
					state_q <= S_SRT_RD;
				end
				S_SRT_RD: begin
					state_q <= (j_q == '0) ? S_SRT_PUT : S_SRT_CMP;
				end
				S_SRT_CMP: begin
					if (cmp.gt) begin
						j_q     <= j_q - 1'b1;
						state_q <= S_SRT_RD;
					end else begin
						state_q <= S_SRT_PUT;
					end
				end
				S_SRT_PUT: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_SRT_LD;
				end
				// linear scan, one match held back to mark the last item
				S_LIN_RD: begin
					if (i_q >= fill_q || n_q == MW'(MAX_RESULTS)) begin
						ret_q   <= S_IDLE;
						state_q <= S_EMIT;
						rsp_q   <= pend_q ?
							'{status: ST_OK, found_index: 6'(pend_idx_q),
							  count: 7'(fill_q), last: 1'b1} :
							'{status: ST_MISS, found_index: '0,
							  count: 7'(fill_q), last: 1'b1};
					end else begin
						state_q <= S_LIN_CMP;
					end
				end
				S_LIN_CMP: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_LIN_RD;
					if (cmp.eq) begin
						n_q        <= n_q + 1'b1;
						pend_q     <= 1'b1;
						pend_idx_q <= i_q;
						if (pend_q) begin
							rsp_q   <= '{status: ST_OK, found_index: 6'(pend_idx_q),
								count: 7'(fill_q), last: 1'b0};
							ret_q   <= S_LIN_RD;
							state_q <= S_EMIT;
						end
					end
				end
				// binary search on sorted entries
				S_BIN_RD: begin
					if (lo_q > hi_q) begin
						rsp_q.status <= ST_MISS;
						state_q      <= S_EMIT;
					end else begin
						mid_q   <= mid;
						state_q <= S_BIN_CMP;
					end
				end
				S_BIN_CMP: begin
					if (cmp.eq) begin
						rsp_q.found_index <= 6'(mid_q);
						state_q <= S_EMIT;
					end else begin
						if (cmp.lt) begin
							lo_q <= mid_q + 1'b1;
						end else begin
							hi_q <= mid_q - 1'b1;
						end
						state_q <= S_BIN_RD;
					end
				end
				// hold the result item until taken
				S_EMIT: begin
					if (!rsp_stall) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/ate_ram.sv */
// ate_ram: entry store, one write and one registered read port
// depends on nothing
module ate_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic signed [31:0]  wdata,
	input  logic [AW-1:0]       raddr,
	output logic signed [31:0]  rdata
);

	logic signed [31:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/ate_cmp.sv */
// ate_cmp: shared signed word comparator
// depends on ate_pkg
module ate_cmp
	import ate_pkg::*;
(
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output cmp_t               res
);

	// signed compare of entry against key
	always_comb begin
		res.eq = (a == b);
		res.gt = (a > b);
		res.lt = (a < b);
	end

endmodule

/* tb/sv/tb_array_table_engine_unit.sv */
// tb_array_table_engine_unit: self-checking testbench for the array table engine
// predicts each item's results with a local table model and checks them in order
// depends on ate_pkg and array_table_engine_unit
`timescale 1ns / 100ps

// holds the predicted results and compares accepted results against them
class rsp_scoreboard;
	ate_pkg::rsp_t pending[$];
	int mismatches;
	int results_seen;

	function new();
		mismatches = 0;
		results_seen = 0;
	endfunction

	// queue the results predicted for one accepted item
	function void note_request(ate_pkg::rsp_t predicted[$]);
		foreach (predicted[i]) pending.push_back(predicted[i]);
	endfunction

	// compare one accepted result with the oldest prediction
	function void check_result(ate_pkg::rsp_t got);
		ate_pkg::rsp_t want;
		results_seen++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result status=%0d idx=%0d count=%0d last=%0d",
					got.status, got.found_index, got.count, got.last);
			return;
		end
		want = pending.pop_front();
		if (got.status !== want.status || got.found_index !== want.found_index ||
				got.count !== want.count || got.last !== want.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected st=%0d idx=%0d cnt=%0d last=%0d, got st=%0d idx=%0d cnt=%0d last=%0d",
					want.status, want.found_index, want.count, want.last,
					got.status, got.found_index, got.count, got.last);
		end
	endfunction
endclass

module tb_array_table_engine_unit;
	import ate_pkg::*;

	localparam int CAP = 64;
	localparam longint CYCLE_LIMIT = 20000000;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	rsp_scoreboard board;
	logic signed [31:0] table_words [CAP];
	int unsigned table_fill;
	longint cycles = 0;
	int items_sent = 0;
	logic signed [31:0] recent_vals [$];

	array_table_engine_unit #(.CAPACITY(CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #10 clk = ~clk;

	function automatic rsp_t make_rsp(logic [1:0] st, int unsigned idx, logic lst);
		rsp_t r;
		r.status = st;
		r.found_index = idx[5:0];
		r.count = table_fill[6:0];
		r.last = lst;
		return r;
	endfunction

	// ascending insertion sort of the filled part of the table
	function automatic void sort_table();
		logic signed [31:0] key;
		int j;
		for (int i = 1; i < table_fill; i++) begin
			key = table_words[i];
			j = i;
			while (j > 0 && table_words[j-1] > key) begin
				table_words[j] = table_words[j-1];
				j--;
			end
			table_words[j] = key;
		end
	endfunction

	function automatic void open_slot(int unsigned pos, logic signed [31:0] v);
		for (int i = table_fill; i > pos; i--) table_words[i] = table_words[i-1];
		table_words[pos] = v;
		table_fill++;
	endfunction

	// work out the results one item causes and update the table
	function automatic void predict_table_op(req_t r, ref rsp_t outq[$]);
		int n;
		int lo, hi, mid;
		bit hit;
		outq.delete();
		case (r.mode)
			OP_FRONT, OP_APPEND: begin
				if (table_fill >= CAP) outq.push_back(make_rsp(ST_FULL, 0, 1));
				else begin
					open_slot(r.mode == OP_FRONT ? 0 : table_fill, r.value);
					outq.push_back(make_rsp(ST_OK, 0, 1));
				end
			end
			OP_INS_AT: begin
				if (r.position > table_fill) outq.push_back(make_rsp(ST_BAD_POS, 0, 1));
				else if (table_fill >= CAP) outq.push_back(make_rsp(ST_FULL, 0, 1));
				else begin
					open_slot(r.position, r.value);
					outq.push_back(make_rsp(ST_OK, 0, 1));
				end
			end
			OP_DEL_AT: begin
				if (r.position >= table_fill) outq.push_back(make_rsp(ST_BAD_POS, 0, 1));
				else begin
					for (int i = r.position; i + 1 < table_fill; i++)
						table_words[i] = table_words[i+1];
					table_fill--;
					outq.push_back(make_rsp(ST_OK, 0, 1));
				end
			end
			OP_SORT: begin
				sort_table();
				outq.push_back(make_rsp(ST_OK, 0, 1));
			end
			OP_LFIND: begin
				n = 0;
				for (int i = 0; i < table_fill && n < MAX_RESULTS; i++)
					if (table_words[i] == r.value) begin
						outq.push_back(make_rsp(ST_OK, i, 0));
						n++;
					end
				if (n == 0) outq.push_back(make_rsp(ST_MISS, 0, 1));
				else outq[n-1].last = 1'b1;
			end
			OP_BFIND: begin
				sort_table();
				lo = 0;
				hi = int'(table_fill) - 1;
				hit = 0;
				while (lo <= hi && !hit) begin
					mid = (lo + hi) / 2;
					if (table_words[mid] == r.value) begin
						outq.push_back(make_rsp(ST_OK, mid, 1));
						hit = 1;
					end else if (r.value > table_words[mid]) lo = mid + 1;
					else hi = mid - 1;
				end
				if (!hit) outq.push_back(make_rsp(ST_MISS, 0, 1));
			end
			default: outq.push_back(make_rsp(ST_OK, 0, 1));
		endcase
	endfunction

	function automatic int gap_len();
		int k = $urandom_range(0, 99);
		if (k < 45) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// values drawn mostly from a small pool so searches hit
	function automatic logic signed [31:0] pick_value();
		int k = $urandom_range(0, 9);
		if (k < 4) return $signed($urandom_range(0, 7)) - 4;
		if (k < 6 && recent_vals.size() > 0)
			return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
		if (k == 6) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		return $signed($urandom());
	endfunction

	// drive one item and wait for its acceptance
	task automatic send_item(logic [2:0] m, logic signed [31:0] v, logic [6:0] p);
		rsp_t predicted[$];
		req_t r;
		// valid was dropped at the last acceptance edge, so always step past that edge and a random gap first
		repeat (gap_len() + 1) @(posedge clk);
		r.mode = m;
		r.value = v;
		r.position = p;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_table_op(r, predicted);
		board.note_request(predicted);
		items_sent++;
		if (recent_vals.size() < 16) recent_vals.push_back(v);
		else recent_vals[$urandom_range(0, 15)] = v;
		req_valid <= 1'b0;
	endtask

	// result side: random stall, check on every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) board.check_result(rsp);
			rsp_stall <= ($urandom_range(0, 99) < 25);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [2:0] m;
		logic [6:0] p;
		int k;
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table edge cases, then extreme values and bad positions on a small table
		send_item(OP_DEL_AT, 0, 0);
		send_item(OP_LFIND, 5, 0);
		send_item(OP_BFIND, 5, 0);
		send_item(OP_SORT, 0, 0);
		send_item(OP_INS_AT, 1, 1);
		send_item(OP_INS_AT, 32'sh7fffffff, 0);
		send_item(OP_FRONT, 32'sh80000000, 0);
		send_item(OP_APPEND, -1, 7'h7f);
		send_item(OP_UNUSED, 32'hffffffff, 7'h7f);
		send_item(OP_LFIND, 32'sh80000000, 0);
		send_item(OP_BFIND, -1, 0);
		send_item(OP_DEL_AT, 0, 3);
		send_item(OP_DEL_AT, 0, 1);
		// fill to capacity with repeats, then full, bad position and many-match cases
		while (table_fill < CAP) send_item(OP_APPEND, 3, 0);
		send_item(OP_FRONT, 1, 0);
		send_item(OP_APPEND, 1, 0);
		send_item(OP_INS_AT, 1, 64);
		send_item(OP_INS_AT, 1, 65);
		send_item(OP_LFIND, 3, 0);
		send_item(OP_BFIND, 3, 0);
		send_item(OP_DEL_AT, 0, 64);
		send_item(OP_DEL_AT, 0, 63);
		// drain the table back down
		while (table_fill > 2)
			send_item(OP_DEL_AT, 0, 7'($urandom_range(0, table_fill - 1)));

		// pause until all results are back
		while (board.pending.size() != 0) @(posedge clk);

		// random: mostly well-formed ops on the live table
		for (int n = 0; n < 175; n++) begin
			k = $urandom_range(0, 99);
			if (k < 18) m = OP_FRONT;
			else if (k < 36) m = OP_APPEND;
			else if (k < 50) m = OP_INS_AT;
			else if (k < 64) m = OP_DEL_AT;
			else if (k < 70) m = OP_SORT;
			else if (k < 84) m = OP_LFIND;
			else if (k < 97) m = OP_BFIND;
			else m = OP_UNUSED;
			if ($urandom_range(0, 9) < 8) p = 7'($urandom_range(0, table_fill));
			else p = 7'($urandom_range(0, 127));
			send_item(m, pick_value(), p);
			if (n == 87) while (board.pending.size() != 0) @(posedge clk);
		end

		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d items and %0d results: inserts, deletes, sorts, searches, full and bad position",
			items_sent, board.results_seen);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d results missing", board.mismatches,
				board.pending.size());
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/ate_pkg.sv
rtl/core/ate_ram.sv
rtl/core/ate_cmp.sv
rtl/core/array_table_engine_unit.sv
tb/sv/tb_array_table_engine_unit.sv
